[src/fcca_pkg.sv]
// ---------------------------------------------------------------------------
// fcca_pkg
// shared types, constants and codes of the fat cluster chain allocator
// ---------------------------------------------------------------------------
package fcca_pkg;

  // table geometry
  localparam int NUM_CLUSTERS = 256;
  localparam int CL_W         = 8;               // cluster index width
  localparam int ENT_W        = 9;               // table entry width
  localparam logic [ENT_W-1:0] FAT_END = '1;     // end-of-chain marker
  localparam logic [ENT_W-1:0] FAT_FREE = '0;

  // free bitmap scan, one word per cycle
  localparam int CHUNK_SH  = 4;
  localparam int CHUNK_W   = 1 << CHUNK_SH;
  localparam int CHUNK_IDX_W = CL_W - CHUNK_SH;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DATA    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLU_TOTAL     = 1'b1;
  localparam logic [CL_W-1:0]      FIRST_DATA_RST    = 8'd1;
  localparam logic [ENT_W-1:0]     CLU_TOTAL_RST     = 9'd256;

  typedef enum logic [1:0] {
    OP_ALLOC      = 2'd0,
    OP_ALLOC_LINK = 2'd1,
    OP_FREE       = 2'd2,
    OP_READ       = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_BAD      = 2'd2,
    ST_BROKEN   = 2'd3
  } st_t;

  typedef struct packed {
    op_t             op;
    logic [CL_W-1:0] cluster;
  } in_item_t;

  typedef struct packed {
    st_t              status;
    logic [CL_W-1:0]  cluster_out;
    logic             is_end;
    logic [ENT_W-1:0] freed_count;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_ALLOC_WR,
    S_LINK_WR,
    S_WALK_RD,
    S_WALK_EV,
    S_READ_WAIT,
    S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic rd_issue;
    logic scan_step;
    logic take_free;
    logic wr_alloc;
    logic wr_link;
    logic walk_adv;
    logic set_st;
    st_t  st;
    logic load_out;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    op_t  op;
    logic c_bad;
    logic cur_used;
    logic steps_over;
    logic scan_found;
    logic scan_last;
    logic ent_end;
    logic ent_oob;
    logic out_free;
  } dp_sts_t;

endpackage

[src/fcca_ctrl.sv]
// ---------------------------------------------------------------------------
// fcca_ctrl
// sequencer for allocate, link, free-chain walk and successor read
// ---------------------------------------------------------------------------
module fcca_ctrl
  import fcca_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        unique case (sts.op)
          OP_ALLOC:      state_nxt = S_SCAN;
          OP_ALLOC_LINK: state_nxt = (sts.c_bad || !sts.cur_used) ? S_DONE : S_SCAN;
          OP_FREE:       state_nxt = sts.c_bad ? S_DONE : S_WALK_RD;
          OP_READ:       state_nxt = sts.c_bad ? S_DONE : S_READ_WAIT;
        endcase
      end
      S_SCAN: begin
        if (sts.scan_found) state_nxt = S_ALLOC_WR;
        else if (sts.scan_last) state_nxt = S_DONE;
      end
      S_ALLOC_WR: begin
        state_nxt = (sts.op == OP_ALLOC_LINK) ? S_LINK_WR : S_DONE;
      end
      S_LINK_WR: state_nxt = S_DONE;
      S_WALK_RD: begin
        state_nxt = (sts.steps_over || !sts.cur_used) ? S_DONE : S_WALK_EV;
      end
      S_WALK_EV: begin
        state_nxt = (sts.ent_end || sts.ent_oob) ? S_DONE : S_WALK_RD;
      end
      S_READ_WAIT: state_nxt = S_DONE;
      S_DONE: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    cmd.st   = ST_OK;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
      end
      S_CHECK: begin
        unique case (sts.op)
          OP_ALLOC: ;
          OP_ALLOC_LINK: begin
            if (sts.c_bad || !sts.cur_used) begin
              cmd.set_st = 1'b1;
              cmd.st     = ST_BAD;
            end
          end
          OP_FREE: begin
            if (sts.c_bad) begin
              cmd.set_st = 1'b1;
              cmd.st     = ST_BAD;
            end
          end
          OP_READ: begin
            if (sts.c_bad) begin
              cmd.set_st = 1'b1;
              cmd.st     = ST_BAD;
            end else begin
              cmd.rd_issue = 1'b1;
            end
          end
        endcase
      end
      S_SCAN: begin
        if (sts.scan_found) begin
          cmd.take_free = 1'b1;
        end else if (sts.scan_last) begin
          cmd.set_st = 1'b1;
          cmd.st     = ST_NO_SPACE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_ALLOC_WR: begin
        cmd.wr_alloc = 1'b1;
        if (sts.op != OP_ALLOC_LINK) begin
          cmd.set_st = 1'b1;
          cmd.st     = ST_OK;
        end
      end
      S_LINK_WR: begin
        cmd.wr_link = 1'b1;
        cmd.set_st  = 1'b1;
        cmd.st      = ST_OK;
      end
      S_WALK_RD: begin
        if (sts.steps_over || !sts.cur_used) begin
          cmd.set_st = 1'b1;
          cmd.st     = ST_BROKEN;
        end else begin
          cmd.rd_issue = 1'b1;
        end
      end
      S_WALK_EV: begin
        cmd.walk_adv = 1'b1;
        if (sts.ent_end) begin
          cmd.set_st = 1'b1;
          cmd.st     = ST_OK;
        end else if (sts.ent_oob) begin
          cmd.set_st = 1'b1;
          cmd.st     = ST_BROKEN;
        end
      end
      S_READ_WAIT: begin
        cmd.set_st = 1'b1;
        cmd.st     = ST_OK;
      end
      S_DONE: begin
        cmd.load_out = sts.out_free;
      end
      default: ;
    endcase
  end

endmodule

[src/fcca_dp.sv]
// ---------------------------------------------------------------------------
// fcca_dp
// table memory, used bitmap, free scan, chain walk and result register
// ---------------------------------------------------------------------------
module fcca_dp
  import fcca_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  in_item_t              in_data,
  output out_item_t             out_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  dp_cmd_t               cmd,
  output dp_sts_t               sts
);

  logic [CL_W-1:0]        fdc_r;
  logic [ENT_W-1:0]       ccnt_r;
  op_t                    op_r;
  logic [CL_W-1:0]        cl_r;
  logic [CL_W-1:0]        cur_r;
  logic [CHUNK_IDX_W-1:0] chunk_r;
  logic [CL_W-1:0]        free_r;
  logic [ENT_W-1:0]       freed_r;
  st_t                    st_r;
  logic [NUM_CLUSTERS-1:0] used_r;
  logic [ENT_W-1:0]       mem [NUM_CLUSTERS];
  logic [ENT_W-1:0]       q_r;
  logic                   usedq_r;
  out_item_t              out_r;
  logic                   out_valid_r;

  logic [ENT_W-1:0]       lim;
  logic [ENT_W-1:0]       ent;
  logic [CHUNK_W-1:0]     chunk_bits;
  logic [CHUNK_W-1:0]     cand;
  logic [CHUNK_SH-1:0]    found_j;
  logic [ENT_W-1:0]       next_base;
  out_item_t              res;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fdc_r  <= FIRST_DATA_RST;
      ccnt_r <= CLU_TOTAL_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_FIRST_DATA: fdc_r  <= cfg_wdata[CL_W-1:0];
        CFG_CLU_TOTAL:  ccnt_r <= cfg_wdata[ENT_W-1:0];
        default: ;
      endcase
    end
  end

  assign lim = (ccnt_r > ENT_W'(NUM_CLUSTERS)) ? ENT_W'(NUM_CLUSTERS) : ccnt_r;

  // free scan over one bitmap word
  assign chunk_bits = used_r[{chunk_r, {CHUNK_SH{1'b0}}} +: CHUNK_W];

  always_comb begin
    logic [CL_W-1:0] idx;
    for (int j = 0; j < CHUNK_W; j++) begin
      idx     = {chunk_r, CHUNK_SH'(j)};
      cand[j] = !chunk_bits[j] && (idx >= fdc_r) && ({1'b0, idx} < lim);
    end
  end

  always_comb begin
    found_j = '0;
    for (int j = CHUNK_W - 1; j >= 0; j--) begin
      if (cand[j]) found_j = CHUNK_SH'(j);
    end
  end

  assign next_base = {({1'b0, chunk_r} + (CHUNK_IDX_W + 1)'(1)), {CHUNK_SH{1'b0}}};

  // item registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r    <= in_data.op;
      cl_r    <= in_data.cluster;
      cur_r   <= in_data.cluster;
      chunk_r <= fdc_r[CL_W-1:CHUNK_SH];
      freed_r <= '0;
    end else begin
      if (cmd.scan_step) chunk_r <= chunk_r + CHUNK_IDX_W'(1);
      if (cmd.walk_adv) begin
        cur_r   <= ent[CL_W-1:0];
        freed_r <= freed_r + ENT_W'(1);
      end
    end
    if (cmd.take_free) free_r <= {chunk_r, found_j};
    if (cmd.set_st) st_r <= cmd.st;
  end

  // used bitmap, an entry not marked used reads as free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else begin
      if (cmd.walk_adv) used_r[cur_r] <= 1'b0;
      if (cmd.wr_alloc) used_r[free_r] <= 1'b1;
      if (cmd.wr_link) used_r[cl_r] <= |free_r;
    end
  end

  // table memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_alloc) begin
      mem[free_r] <= FAT_END;
    end else if (cmd.wr_link) begin
      mem[cl_r] <= {1'b0, free_r};
    end
    if (cmd.rd_issue) begin
      q_r     <= mem[cur_r];
      usedq_r <= used_r[cur_r];
    end
  end

  assign ent = usedq_r ? q_r : FAT_FREE;

  // result assembly
  always_comb begin
    res             = '0;
    res.status      = st_r;
    res.freed_count = (op_r == OP_FREE) ? freed_r : '0;
    if (st_r == ST_OK) begin
      if (op_r == OP_ALLOC || op_r == OP_ALLOC_LINK) begin
        res.cluster_out = free_r;
      end else if (op_r == OP_READ) begin
        if (ent == FAT_END) res.is_end = 1'b1;
        else res.cluster_out = ent[CL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) out_r <= res;
  end

  assign out_data  = out_r;
  assign out_valid = out_valid_r;

  assign sts.op         = op_r;
  assign sts.c_bad      = {1'b0, cur_r} >= lim;
  assign sts.cur_used   = used_r[cur_r];
  assign sts.steps_over = freed_r >= lim;
  assign sts.scan_found = |cand;
  assign sts.scan_last  = next_base >= lim;
  assign sts.ent_end    = ent == FAT_END;
  assign sts.ent_oob    = ent >= lim;
  assign sts.out_free   = !out_valid_r || out_ready;

endmodule

[src/fat_cluster_chain_allocator.sv]
// ---------------------------------------------------------------------------
// fat_cluster_chain_allocator
// Keeps a 256-entry file allocation table and serves one command item at a
// time: allocate the lowest free cluster at or above first_data_cluster
// (optionally linking it after a given cluster), free a whole chain while
// counting the released clusters, or read a cluster's successor. The table
// is free after reset with no clearing pass: a used bit per cluster marks
// live entries, so the block takes items from the first cycle. Each item
// gives one result. An item is accepted, checked and its result loaded into
// the result register; between check and load, a successor read adds a
// table read; an allocation adds a free bitmap scan, 16 clusters per cycle
// starting at the word holding first_data_cluster, and a table write (and a
// link write when linking); a chain free adds a read and an evaluate state
// per cluster walked, through the single table read port, and ends in the
// read state, with no read, when the walk stops on a free entry or the step
// limit. The result register frees the input side, so a new item is taken
// while the previous result waits.
module fat_cluster_chain_allocator
  import fcca_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // command items
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  // result items
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer: one state per table access or scan step
  fcca_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // table, used bitmap, scan word select and result register
  fcca_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // one item in flight: ready drops right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while another is in flight");

  // end-of-chain is only reported by a good read, with no successor
  a_end_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_end |->
      out_data.status == ST_OK && out_data.cluster_out == '0 &&
      out_data.freed_count == '0)
    else $error("end-of-chain with inconsistent result fields");

  // clusters are released only by an ok or broken chain walk
  a_freed_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.freed_count != '0 |->
      out_data.status == ST_OK || out_data.status == ST_BROKEN)
    else $error("freed count with bad or no-space status");

  // no-space carries no cluster
  a_no_space_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_NO_SPACE |->
      out_data.cluster_out == '0 && out_data.freed_count == '0)
    else $error("no-space result with cluster fields set");

endmodule

[tb/testbench.sv]
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for fat_cluster_chain_allocator. A scoreboard keeps its
// own copy of the allocation table and both registers. For every accepted
// command item it predicts the result item, and each result item is checked
// field by field in order. A short directed pass covers the table corner
// cases. Random phases follow, one per register setting, most with random
// stalls on both channels.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import fcca_pkg::*;

  // shadow of the allocation table plus the queue of predicted result items
  class chain_scoreboard;
    logic [ENT_W-1:0] fat_copy [NUM_CLUSTERS];
    logic [CL_W-1:0]  first_data;
    logic [ENT_W-1:0] clu_total;
    out_item_t        expected_q [$];
    int               errors;

    function new();
      foreach (fat_copy[i]) fat_copy[i] = FAT_FREE;
      first_data = FIRST_DATA_RST;
      clu_total  = CLU_TOTAL_RST;
      errors     = 0;
    endfunction

    // counts above the table size clamp to the table size
    function int limit();
      return (clu_total < NUM_CLUSTERS) ? int'(clu_total) : NUM_CLUSTERS;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      if (idx == CFG_FIRST_DATA) begin
        first_data = value[CL_W-1:0];
      end else begin
        clu_total = value;
      end
    endfunction

    // predict the result of one accepted command item and update the table
    function void note_command(in_item_t cmd);
      int lim, f, i, cur, steps, freed;
      logic [ENT_W-1:0] nxt;
      out_item_t res;
      lim   = limit();
      res   = '0;
      freed = 0;
      case (cmd.op)
        OP_ALLOC, OP_ALLOC_LINK: begin
          // linking needs a live cluster in range to hang the new one on
          if (cmd.op == OP_ALLOC_LINK &&
              (cmd.cluster >= lim || fat_copy[cmd.cluster] == FAT_FREE)) begin
            res.status = ST_BAD;
          end else begin
            f = lim;
            for (i = int'(first_data); i < lim; i++) begin
              if (fat_copy[i] == FAT_FREE) begin
                f = i;
                break;
              end
            end
            if (f >= lim) begin
              res.status = ST_NO_SPACE;
            end else begin
              fat_copy[f] = FAT_END;
              if (cmd.op == OP_ALLOC_LINK) fat_copy[cmd.cluster] = f[ENT_W-1:0];
              res.cluster_out = f[CL_W-1:0];
            end
          end
        end
        OP_FREE: begin
          if (cmd.cluster >= lim) begin
            res.status = ST_BAD;
          end else begin
            // walk the chain, releasing every entry visited
            cur   = int'(cmd.cluster);
            steps = 0;
            while (1) begin
              if (steps >= lim || fat_copy[cur] == FAT_FREE) begin
                res.status = ST_BROKEN;
                break;
              end
              nxt           = fat_copy[cur];
              fat_copy[cur] = FAT_FREE;
              freed++;
              steps++;
              if (nxt == FAT_END) break;
              if (nxt >= lim) begin
                res.status = ST_BROKEN;
                break;
              end
              cur = int'(nxt);
            end
          end
          res.freed_count = freed[ENT_W-1:0];
        end
        default: begin
          if (cmd.cluster >= lim) begin
            res.status = ST_BAD;
          end else if (fat_copy[cmd.cluster] == FAT_END) begin
            res.is_end = 1'b1;
          end else begin
            res.cluster_out = fat_copy[cmd.cluster][CL_W-1:0];
          end
        end
      endcase
      expected_q.push_back(res);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        $error("result item with no command waiting: %h", got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.cluster_out !== want.cluster_out) begin
        $error("cluster_out: expected %0d, got %0d", want.cluster_out, got.cluster_out);
        errors++;
      end
      if (got.is_end !== want.is_end) begin
        $error("is_end: expected %0d, got %0d", want.is_end, got.is_end);
        errors++;
      end
      if (got.freed_count !== want.freed_count) begin
        $error("freed_count: expected %0d, got %0d", want.freed_count, got.freed_count);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;

  // stall switches, set per phase by the main sequence
  bit in_stall_on  = 1'b1;
  bit out_stall_on = 1'b1;

  chain_scoreboard sb = new();

  // register settings of the random phases: zero and top first cluster,
  // smallest count, empty range and counts past the table size
  int phase_first [8] = '{1, 0, 255, 16, 200, 1, 3, 2};
  int phase_count [8] = '{256, 256, 256, 64, 100, 2, 300, 511};

  fat_cluster_chain_allocator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  // gap length: mostly short, now and then long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    else if (r < 95) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  function automatic in_item_t command_item(op_t op, logic [CL_W-1:0] c);
    in_item_t it;
    it.op      = op;
    it.cluster = c;
    return it;
  endfunction

  // a live cluster below the limit, only a chain tail when asked;
  // falls back to any index when the table holds nothing usable
  function automatic logic [CL_W-1:0] pick_cluster(bit want_tail);
    int lim, s, i, c;
    lim = sb.limit();
    s   = int'($urandom_range(0, lim - 1));
    for (i = 0; i < lim; i++) begin
      c = (s + i) % lim;
      if (sb.fat_copy[c] != FAT_FREE && (!want_tail || sb.fat_copy[c] == FAT_END))
        return c[CL_W-1:0];
    end
    return CL_W'($urandom_range(0, 255));
  endfunction

  // mostly chain building on live clusters, some frees and reads,
  // plus a share of arbitrary indexes as noise
  function automatic in_item_t random_command();
    int r;
    op_t op;
    logic [CL_W-1:0] c;
    r = $urandom_range(0, 99);
    if (r < 25) op = OP_ALLOC;
    else if (r < 55) op = OP_ALLOC_LINK;
    else if (r < 78) op = OP_FREE;
    else op = OP_READ;
    r = $urandom_range(0, 99);
    if (op == OP_ALLOC || r < 10) c = CL_W'($urandom_range(0, 255));
    else if (r < 25) c = CL_W'($urandom_range(0, sb.limit() - 1));
    else c = pick_cluster(op == OP_ALLOC_LINK && r < 70);
    return command_item(op, c);
  endfunction

  // called at a falling edge; leaves valid high so a back-to-back item
  // does not drop it for a step
  task automatic send_command(in_item_t cmd);
    int gap;
    gap = (in_stall_on && $urandom_range(0, 2) == 0) ? gap_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= cmd;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_command(cmd);
    @(negedge clk);
  endtask

  // every command gives a result, so an empty queue means the block is idle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  // both registers, back to back, with the write enable held across them
  task automatic set_config(int first, int count);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_FIRST_DATA;
    cfg_wdata <= CFG_DATA_W'(first);
    @(posedge clk);
    sb.write_reg(CFG_FIRST_DATA, CFG_DATA_W'(first));
    @(negedge clk);
    cfg_idx   <= CFG_CLU_TOTAL;
    cfg_wdata <= CFG_DATA_W'(count);
    @(posedge clk);
    sb.write_reg(CFG_CLU_TOTAL, CFG_DATA_W'(count));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // result side: ready held low for random stretches
  initial begin
    int hold;
    hold      = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (out_stall_on && $urandom_range(0, 3) == 0) hold = gap_len();
      end
    end
  end

  // result monitor, sampled at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready) sb.check_result(out_data);
  end

  initial begin
    int p;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = CFG_FIRST_DATA;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: first cluster 1, whole table
    send_command(command_item(OP_READ, 8'd0));        // free entry reads as 0
    send_command(command_item(OP_ALLOC, 8'hFF));      // cluster ignored
    send_command(command_item(OP_ALLOC_LINK, 8'd1));
    send_command(command_item(OP_ALLOC_LINK, 8'd2));
    send_command(command_item(OP_READ, 8'd1));
    send_command(command_item(OP_READ, 8'd3));        // end-of-chain marker
    send_command(command_item(OP_ALLOC_LINK, 8'd200)); // link after free cluster
    send_command(command_item(OP_ALLOC_LINK, 8'd1));  // overwrites an old link
    send_command(command_item(OP_FREE, 8'd2));        // orphaned tail
    send_command(command_item(OP_FREE, 8'd1));
    send_command(command_item(OP_FREE, 8'd1));        // free start
    send_command(command_item(OP_ALLOC, 8'd0));
    send_command(command_item(OP_ALLOC_LINK, 8'd1));
    send_command(command_item(OP_FREE, 8'd2));
    send_command(command_item(OP_FREE, 8'd1));        // chain runs into a free entry
    send_command(command_item(OP_READ, 8'd255));

    // allocation from cluster 0 in a two-cluster table
    wait_idle();
    set_config(0, 2);
    send_command(command_item(OP_ALLOC, 8'd0));
    send_command(command_item(OP_ALLOC, 8'd0));
    send_command(command_item(OP_ALLOC, 8'd0));       // table full
    send_command(command_item(OP_READ, 8'd2));        // out of range
    send_command(command_item(OP_FREE, 8'd255));
    send_command(command_item(OP_ALLOC_LINK, 8'd2));
    send_command(command_item(OP_FREE, 8'd0));

    // successor beyond a lowered limit
    wait_idle();
    set_config(250, 256);
    send_command(command_item(OP_ALLOC, 8'd0));
    send_command(command_item(OP_ALLOC_LINK, 8'd250));
    wait_idle();
    set_config(250, 251);
    send_command(command_item(OP_FREE, 8'd250));

    // first cluster at the limit: nothing to allocate
    wait_idle();
    set_config(255, 255);
    send_command(command_item(OP_ALLOC, 8'd0));

    // random phases; one runs with no stalls at all
    for (p = 0; p < 8; p++) begin
      wait_idle();
      set_config(phase_first[p], phase_count[p]);
      in_stall_on  = (p != 1) && ($urandom_range(0, 3) != 0);
      out_stall_on = (p != 1) && ($urandom_range(0, 3) != 0);
      repeat (130) send_command(random_command());
    end

    wait_idle();
    repeat (50) @(negedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #100_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
